// ===== rtl/sackw_pkg.sv =====
`default_nettype none

package sackw_pkg;

  // Serial-number arithmetic: a forward distance below half the sequence space is newer.
  localparam logic [15:0] SERIAL_HALF = 16'h8000;

  typedef enum logic [1:0] {
    ACT_RECEIVE   = 2'd0,
    ACT_QUERY     = 2'd1,
    ACT_READ_WORD = 2'd2,
    ACT_NOP       = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_ACCEPTED      = 2'd0,
    STAT_DUPLICATE     = 2'd1,
    STAT_OUT_OF_WINDOW = 2'd2
  } status_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] sequence_req;
    logic [1:0]  word_sel;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic        is_acked;
    logic [15:0] newest_sequence;
    logic [63:0] history_word;
    logic        ready_flag;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/sequence_ack_window_256_core.sv =====
`default_nettype none

// Anti-replay acknowledgement window for 16-bit packet sequence numbers. Each input
// transaction is a receive, an acked query, a history word read or a no-op; each produces
// exactly one result transaction, in order. Newness uses serial-number arithmetic modulo
// 65536. The first receive after reset adopts its sequence; newer ones slide a
// WINDOW_BITS-wide history; older ones within the window are accepted once and reported
// duplicate after; anything further behind is out of window. Throughput is one transaction
// per cycle while the result side is not stalled: the whole update (barrel shift of the
// history, bit test and bit set) is combinational logic between the input register and
// the result register, so the next item sees the state the previous one left. An item
// waits in the input register until the result register is free or being drained. in_ready
// depends combinationally on out_ready through the pipeline advance.
module sequence_ack_window_256_core #(
  parameter int WINDOW_BITS = 256
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sackw_pkg::in_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sackw_pkg::out_t     out_data
);

  // Input register holding the next transaction to process.
  logic            s1_valid;
  sackw_pkg::in_t  s1_item;
  logic            advance;
  sackw_pkg::out_t result;

  // Process the held item whenever the result register is free or being drained.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  sackw_window #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_window (
    .clk   (clk),
    .rst   (rst),
    .en    (advance),
    .item  (s1_item),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  // Result register: load on advance, drop when taken with nothing behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed transaction did not reach the result register");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_item))
    else $error("held transaction lost during stall");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !advance)
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

// ===== rtl/sackw_window.sv =====
`default_nettype none

module sackw_window #(
  parameter int WINDOW_BITS = 256
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire sackw_pkg::in_t item,
  output sackw_pkg::out_t     result
);

  localparam int IDX_W     = $clog2(WINDOW_BITS);
  localparam int HWORDS    = (WINDOW_BITS + 63) / 64;
  localparam int PAD_WORDS = (HWORDS > 4) ? HWORDS : 4;
  localparam logic [15:0] WIN_LIMIT = 16'(WINDOW_BITS);
  localparam logic [WINDOW_BITS-1:0] BIT0 = WINDOW_BITS'(1);

  logic [15:0]            newest_seq;
  logic [15:0]            newest_seq_next;
  logic [WINDOW_BITS-1:0] history;
  logic [WINDOW_BITS-1:0] history_next;
  logic                   started;
  logic                   started_next;

  logic [15:0]            ahead;
  logic [15:0]            behind;
  logic [15:0]            ahead_m1;
  logic [15:0]            behind_m1;
  logic                   is_newer;
  logic                   ahead_in;
  logic                   behind_in;
  logic                   hit;
  logic [WINDOW_BITS-1:0] shifted;
  logic [WINDOW_BITS-1:0] mark_ahead;
  logic [WINDOW_BITS-1:0] mark_behind;
  logic [PAD_WORDS*64-1:0] padded;
  sackw_pkg::status_t     status;
  logic                   acked;
  logic [63:0]            hword;

  assign ahead     = item.sequence_req - newest_seq;
  assign behind    = newest_seq - item.sequence_req;
  assign ahead_m1  = ahead - 16'd1;
  assign behind_m1 = behind - 16'd1;
  assign is_newer  = (ahead != 16'd0) && (ahead < sackw_pkg::SERIAL_HALF);
  assign ahead_in  = (ahead != 16'd0) && (ahead <= WIN_LIMIT);
  assign behind_in = (behind != 16'd0) && (behind <= WIN_LIMIT);
  assign hit       = behind_in && history[behind_m1[IDX_W-1:0]];

  // Drop everything on a jump of a full window or more.
  assign shifted     = (ahead >= WIN_LIMIT) ? '0 : (history << ahead[IDX_W-1:0]);
  assign mark_ahead  = ahead_in ? (BIT0 << ahead_m1[IDX_W-1:0]) : '0;
  assign mark_behind = behind_in ? (BIT0 << behind_m1[IDX_W-1:0]) : '0;

  always_comb begin
    padded = '0;
    padded[WINDOW_BITS-1:0] = history;
  end

  always_comb begin
    newest_seq_next = newest_seq;
    history_next    = history;
    started_next    = started;
    status          = sackw_pkg::STAT_ACCEPTED;
    acked           = 1'b0;
    hword           = '0;
    unique case (item.action)
      sackw_pkg::ACT_RECEIVE: begin
        if (!started) begin
          newest_seq_next = item.sequence_req;
          history_next    = '0;
          started_next    = 1'b1;
        end else if (ahead == 16'd0) begin
          status = sackw_pkg::STAT_DUPLICATE;
        end else if (is_newer) begin
          history_next    = shifted | mark_ahead;
          newest_seq_next = item.sequence_req;
        end else if (!behind_in) begin
          status = sackw_pkg::STAT_OUT_OF_WINDOW;
        end else if (hit) begin
          status = sackw_pkg::STAT_DUPLICATE;
        end else begin
          history_next = history | mark_behind;
        end
      end
      sackw_pkg::ACT_QUERY: begin
        acked = started && ((ahead == 16'd0) || hit);
      end
      sackw_pkg::ACT_READ_WORD: begin
        if (started) begin
          hword = padded[{item.word_sel, 6'd0} +: 64];
        end
      end
      sackw_pkg::ACT_NOP: begin
      end
    endcase
  end

  always_comb begin
    result.status          = status;
    result.is_acked        = acked;
    result.newest_sequence = started_next ? newest_seq_next : 16'd0;
    result.history_word    = hword;
    result.ready_flag      = started_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_seq <= '0;
      history    <= '0;
      started    <= 1'b0;
    end else if (en) begin
      newest_seq <= newest_seq_next;
      history    <= history_next;
      started    <= started_next;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !started |-> (newest_seq == 16'd0) && (history == '0))
    else $error("state not clean while unstarted");

  a_started_sticks: assert property (@(posedge clk) disable iff (rst)
    started |=> started)
    else $error("started flag dropped");

  a_newer_adopted: assert property (@(posedge clk) disable iff (rst)
    en && started && (item.action == sackw_pkg::ACT_RECEIVE) && is_newer
    |=> newest_seq == $past(item.sequence_req))
    else $error("newer sequence not adopted");

endmodule

`default_nettype wire

// ===== bench/sackw_window_checker.sv =====
`timescale 1ns / 1ps

module sackw_window_checker (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_ready,
  input  wire sackw_pkg::in_t  in_data,
  input  wire logic            out_valid,
  input  wire logic            out_ready,
  input  wire sackw_pkg::out_t out_data,
  output int                   fail_count,
  output int                   outstanding
);

  localparam int WINDOW = 256;
  localparam int IDX_W  = $clog2(WINDOW);

  logic [15:0]       shadow_newest  = '0;
  logic [WINDOW-1:0] shadow_history = '0;
  logic              shadow_started = 1'b0;

  sackw_pkg::out_t expected_results[$];
  int   mismatch_count = 0;
  int   result_count   = 0;

  assign fail_count = mismatch_count;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at result %0d: %s got %h want %h", result_count, what, got, want);
    mismatch_count++;
  endtask

  // Apply one transaction to the shadow window and return the result it must produce.
  // History bit k stands for the sequence k+1 behind the newest.
  function automatic sackw_pkg::out_t next_window_result(input sackw_pkg::in_t item);
    sackw_pkg::out_t r;
    logic [15:0]     ahead;
    logic [15:0]     behind;
    r      = '0;
    ahead  = item.sequence_req - shadow_newest;
    behind = shadow_newest - item.sequence_req;
    case (item.action)
      sackw_pkg::ACT_RECEIVE: begin
        if (!shadow_started) begin
          shadow_newest  = item.sequence_req;
          shadow_history = '0;
          shadow_started = 1'b1;
          r.status       = sackw_pkg::STAT_ACCEPTED;
        end else if (ahead == 16'd0) begin
          r.status = sackw_pkg::STAT_DUPLICATE;
        end else if (ahead < sackw_pkg::SERIAL_HALF) begin
          if (ahead >= WINDOW) shadow_history = '0;
          else shadow_history = shadow_history << ahead;
          if (ahead <= WINDOW) shadow_history[IDX_W'(ahead - 16'd1)] = 1'b1;
          shadow_newest = item.sequence_req;
          r.status      = sackw_pkg::STAT_ACCEPTED;
        end else if (behind > WINDOW) begin
          r.status = sackw_pkg::STAT_OUT_OF_WINDOW;
        end else if (shadow_history[IDX_W'(behind - 16'd1)]) begin
          r.status = sackw_pkg::STAT_DUPLICATE;
        end else begin
          shadow_history[IDX_W'(behind - 16'd1)] = 1'b1;
          r.status = sackw_pkg::STAT_ACCEPTED;
        end
      end
      sackw_pkg::ACT_QUERY: begin
        if (shadow_started) begin
          if (behind == 16'd0) r.is_acked = 1'b1;
          else if (behind <= WINDOW) r.is_acked = shadow_history[IDX_W'(behind - 16'd1)];
        end
      end
      sackw_pkg::ACT_READ_WORD: begin
        if (shadow_started) r.history_word = shadow_history[{item.word_sel, 6'd0} +: 64];
      end
      default: ;
    endcase
    r.newest_sequence = shadow_started ? shadow_newest : 16'd0;
    r.ready_flag      = shadow_started;
    return r;
  endfunction

  always @(posedge clk) begin
    sackw_pkg::out_t want;
    if (rst) begin
      expected_results.delete();
      shadow_newest  = '0;
      shadow_history = '0;
      shadow_started = 1'b0;
      outstanding   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("transaction with nothing expected", 64'(out_data), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 64'(out_data.status), 64'(want.status));
          if (out_data.is_acked !== want.is_acked)
            report_mismatch("is_acked", 64'(out_data.is_acked), 64'(want.is_acked));
          if (out_data.newest_sequence !== want.newest_sequence)
            report_mismatch("newest_sequence", 64'(out_data.newest_sequence),
                            64'(want.newest_sequence));
          if (out_data.history_word !== want.history_word)
            report_mismatch("history_word", out_data.history_word, want.history_word);
          if (out_data.ready_flag !== want.ready_flag)
            report_mismatch("ready_flag", 64'(out_data.ready_flag), 64'(want.ready_flag));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(next_window_result(in_data));
      outstanding <= expected_results.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  sackw_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  sackw_pkg::out_t out_data;

  int fail_count;
  int outstanding;

  // Traffic shaping, changed per phase. Percentages are chances out of a hundred.
  int idle_pct         = 0;
  int stall_pct        = 0;
  bit hold_off_request = 1'b0;

  // Rough copy of the newest sequence, used only to aim random sequences near the window.
  logic [15:0] aim_newest  = '0;
  bit          aim_started = 1'b0;

  sequence_ack_window_256_core #(
    .WINDOW_BITS(256)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sackw_window_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshake locks up.
  initial begin
    #2_000_000;
    $display("[sequence_ack_window_256_core] ERROR");
    $finish;
  end

  // Result side: stall at the phase's rate, or hold off for a long stretch on request so
  // the pipeline fills and in_ready drops while the sender keeps offering transactions.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off_request = 1'b0;
      end else begin
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic sackw_pkg::in_t mk(input sackw_pkg::action_t act,
                                        input logic [15:0] seq, input logic [1:0] widx);
    sackw_pkg::in_t item;
    item.action       = act;
    item.sequence_req = seq;
    item.word_sel     = widx;
    return item;
  endfunction

  // Follow the newest sequence the way serial arithmetic does, to keep offsets meaningful.
  function automatic void track_newest(input sackw_pkg::in_t item);
    logic [15:0] ahead;
    ahead = item.sequence_req - aim_newest;
    if (item.action != sackw_pkg::ACT_RECEIVE) return;
    if (!aim_started || (ahead != 16'd0 && ahead < sackw_pkg::SERIAL_HALF))
      aim_newest = item.sequence_req;
    aim_started = 1'b1;
  endfunction

  // Mostly receives around the newest sequence: small forward steps, late arrivals inside
  // the window, edge distances and long jumps; the rest queries, word reads and no-ops.
  function automatic sackw_pkg::in_t random_item();
    sackw_pkg::in_t item;
    int             pick;
    logic [15:0]    off;
    item.word_sel = 2'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 60)      item.action = sackw_pkg::ACT_RECEIVE;
    else if (pick < 80) item.action = sackw_pkg::ACT_QUERY;
    else if (pick < 95) item.action = sackw_pkg::ACT_READ_WORD;
    else                item.action = sackw_pkg::ACT_NOP;
    pick = $urandom_range(99);
    if (item.action == sackw_pkg::ACT_RECEIVE) begin
      if (pick < 35)      off = 16'($urandom_range(4, 1));
      else if (pick < 65) off = -16'($urandom_range(260, 1));
      else if (pick < 75) off = 16'($urandom_range(300, 1));
      else if (pick < 80) off = 16'd0;
      else if (pick < 85) off = 16'($urandom_range(32767, 1));
      else if (pick < 90) off = -16'($urandom_range(32768, 257));
      else if (pick < 95) off = pick[0] ? 16'd256 : -16'd256;
      else                off = 16'($urandom_range(16'hFFFF));
    end else begin
      if (pick < 70)      off = -16'($urandom_range(260, 0));
      else if (pick < 85) off = 16'($urandom_range(4, 1));
      else                off = 16'($urandom_range(16'hFFFF));
    end
    item.sequence_req = aim_newest + off;
    return item;
  endfunction

  // Offer one transaction and hold it until accepted; then maybe go idle for a random gap.
  // Valid stays high straight into the next call when no gap is taken.
  task automatic send_item(input sackw_pkg::in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_newest(item);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result is back, plus the pipeline latency.
  // Wait on the clock first so the count includes the transaction just accepted.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    sackw_pkg::in_t directed[$];

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Before the first receive every query reads as zero.
    directed.push_back(mk(sackw_pkg::ACT_QUERY, 16'h1234, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_READ_WORD, 16'h0000, 2'd3));
    directed.push_back(mk(sackw_pkg::ACT_NOP, 16'hFFFF, 2'd3));
    // Adopt the first sequence, then repeat it: the newest itself is a duplicate.
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'hFFF0, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'hFFF0, 2'd1));
    // Step forward across the wrap, then fill a hole behind and hit it again.
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'h0005, 2'd2));
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'hFFF8, 2'd3));
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'hFFF8, 2'd0));
    // Oldest slot in the window, then one past it.
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'hFF05, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'hFF04, 2'd0));
    // Query the newest, the oldest slot, and a sequence ahead of the newest.
    directed.push_back(mk(sackw_pkg::ACT_QUERY, 16'h0005, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_QUERY, 16'hFF05, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_QUERY, 16'h0006, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_READ_WORD, 16'h0000, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_READ_WORD, 16'h0000, 2'd3));
    // Jump of exactly the window: only the previous newest survives, in the top bit.
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'h0105, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_READ_WORD, 16'hFFFF, 2'd3));
    // Jump one past the window: history ends empty.
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'h0206, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_READ_WORD, 16'h0000, 2'd3));
    // Largest forward distance, then exactly half the space away (counts as behind).
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'h8205, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'h0205, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_NOP, 16'h0000, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_READ_WORD, 16'h0000, 2'd1));
    directed.push_back(mk(sackw_pkg::ACT_QUERY, 16'h0000, 2'd0));
    directed.push_back(mk(sackw_pkg::ACT_RECEIVE, 16'h0000, 2'd0));

    foreach (directed[i]) send_item(directed[i]);
    wait_for_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          // Back up the result side while transactions keep coming.
          hold_off_request = 1'b1;
        end
        1: begin
          idle_pct  = 65;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 65;
        end
        default: begin
          idle_pct  = 16;
          stall_pct = 16;
        end
      endcase
      repeat (190) send_item(random_item());
      wait_for_results();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[sequence_ack_window_256_core] OK");
    end else begin
      $display("[sequence_ack_window_256_core] ERROR");
    end
    $finish;
  end

endmodule
